FILE: rtl/bdad_pkg.sv
// ----------------------------------------------------------------------------
// bdad_pkg
// Shared constants for the binary to decimal ASCII digit converter.
// ----------------------------------------------------------------------------
package bdad_pkg;

    // Bits in one BCD digit.
    localparam int DIGIT_BITS = 4;

    // Binary bits consumed by the converter in each cycle.
    localparam int BITS_PER_STEP = 4;

    // ASCII code of the character '0', cut to the width of the result field.
    localparam logic [5:0] ASCII_ZERO = 6'd48;

endpackage

FILE: rtl/bdad_front.sv
// ----------------------------------------------------------------------------
// bdad_front
// Accepts a binary value and converts it to BCD by shift and add-3,
// four bits per cycle, then hands the digits and the index of the
// leading nonzero digit to the queue.
// ----------------------------------------------------------------------------
module bdad_front import bdad_pkg::*; #(
    parameter int VALUE_WIDTH = 16,
    parameter int NDIG        = 5,
    parameter int CW          = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    output logic                         o_full,
    input  logic [VALUE_WIDTH-1:0]       i_value,
    output logic                         o_q_push,
    input  logic                         i_q_full,
    output logic [NDIG*DIGIT_BITS-1:0]   o_bcd,
    output logic [CW-1:0]                o_top
);

    localparam int NSTEP = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int PW    = NSTEP * BITS_PER_STEP;
    localparam int BW    = NDIG * DIGIT_BITS;
    localparam int SW    = $clog2(NSTEP + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_bin, n_bin;
    logic [BW-1:0]   r_bcd, n_bcd;
    logic [SW-1:0]   r_step, n_step;
    logic [BW-1:0]   v_bcd;
    logic [PW-1:0]   v_bin;
    logic            w_accept;
    logic [CW-1:0]   w_top;

    assign o_full   = !((r_state == S_IDLE) || ((r_state == S_DONE) && !i_q_full));
    assign w_accept = i_push && !o_full;
    assign o_q_push = (r_state == S_DONE) && !i_q_full;
    assign o_bcd    = r_bcd;
    assign o_top    = w_top;

    // One step of double dabble: BITS_PER_STEP bit shifts, each preceded
    // by the add-3 correction on every digit.
    always_comb begin
        v_bcd = r_bcd;
        v_bin = r_bin;
        for (int b = 0; b < BITS_PER_STEP; b++) begin
            for (int d = 0; d < NDIG; d++) begin
                if (v_bcd[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
                    v_bcd[d*DIGIT_BITS +: DIGIT_BITS] =
                        v_bcd[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
                end
            end
            v_bcd = {v_bcd[BW-2:0], v_bin[PW-1]};
            v_bin = {v_bin[PW-2:0], 1'b0};
        end
    end

    // Highest nonzero digit; zero shows as a single digit.
    always_comb begin
        w_top = '0;
        for (int d = 1; d < NDIG; d++) begin
            if (r_bcd[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
                w_top = CW'(d);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE, S_DONE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                    n_bin   = PW'(i_value);
                    n_bcd   = '0;
                    n_step  = '0;
                end else if (r_state == S_DONE && !i_q_full) begin
                    n_state = S_IDLE;
                end
            end
            S_CONV: begin
                n_bin  = v_bin;
                n_bcd  = v_bcd;
                n_step = r_step + 1'b1;
                if (r_step == SW'(NSTEP - 1)) begin
                    n_state = S_DONE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

endmodule

FILE: rtl/bdad_queue.sv
// ----------------------------------------------------------------------------
// bdad_queue
// Two-entry register queue between the converter and the digit emitter.
// ----------------------------------------------------------------------------
module bdad_queue import bdad_pkg::*; #(
    parameter int WIDTH = 23
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count, n_count;
    logic             w_wr, w_rd;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (w_wr && !w_rd) begin
            n_count = r_count + 2'd1;
        end else if (w_rd && !w_wr) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
        end
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

FILE: rtl/bdad_back.sv
// ----------------------------------------------------------------------------
// bdad_back
// Walks the queued BCD digits from the leading nonzero digit down to the
// units digit and drives one ASCII character per cycle into the result
// register while an entry waits and the register is empty or popped.
// ----------------------------------------------------------------------------
module bdad_back import bdad_pkg::*; #(
    parameter int NDIG = 5,
    parameter int CW   = 3
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  logic [NDIG*DIGIT_BITS-1:0]  i_bcd,
    input  logic [CW-1:0]               i_top,
    output logic                        o_q_pop,
    output logic                        o_empty,
    input  logic                        i_pop,
    output logic [5:0]                  o_digit_char,
    output logic                        o_last
);

    logic                  r_valid;
    logic                  r_busy;
    logic [CW-1:0]         r_idx;
    logic [5:0]            r_char;
    logic                  r_last;
    logic [CW-1:0]         w_idx;
    logic [DIGIT_BITS-1:0] w_digit;
    logic                  w_load;

    // A fresh entry starts at its leading digit.
    assign w_idx   = r_busy ? r_idx : i_top;
    assign w_digit = i_bcd[w_idx*DIGIT_BITS +: DIGIT_BITS];
    assign w_load  = !i_q_empty && (!r_valid || i_pop);
    assign o_q_pop = w_load && (w_idx == '0);

    assign o_empty      = !r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_busy  <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (w_load) begin
                r_valid <= 1'b1;
                r_busy  <= (w_idx != '0);
                r_idx   <= w_idx - 1'b1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
        if (w_load) begin
            r_char <= ASCII_ZERO + 6'(w_digit);
            r_last <= (w_idx == '0);
        end
    end

endmodule

FILE: rtl/binary_to_decimal_ascii_digits.sv
// A value passes the shift and add-3 loop, then the queue, then the result register.
// The converter takes a new value only after its four-bits-per-cycle shift and add-3
// loop is through with the last; the emitter gives one character per cycle while an
// entry waits and the result register is empty or popped.
// Reset: synchronous, active low; it empties the queue and the result register.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_digits
// Unsigned binary to decimal ASCII characters with leading zeros blanked.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_digits import bdad_pkg::*; #(
    parameter int VALUE_WIDTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   empty,
    input  logic                   pop,
    output logic [5:0]             o_digit_char,
    output logic                   o_last
);

    // Decimal digits of 2^VALUE_WIDTH - 1; 1233/4096 approximates log10(2).
    localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int CW   = $clog2(NDIG);
    localparam int BW   = NDIG * DIGIT_BITS;
    localparam int QW   = BW + CW;

    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;
    logic [BW-1:0] w_f_bcd;
    logic [CW-1:0] w_f_top;
    logic [QW-1:0] w_q_out;

    bdad_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NDIG        (NDIG),
        .CW          (CW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_value  (i_value),
        .o_q_push (w_q_push),
        .i_q_full (w_q_full),
        .o_bcd    (w_f_bcd),
        .o_top    (w_f_top)
    );

    bdad_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  ({w_f_bcd, w_f_top}),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out),
        .o_empty (w_q_empty)
    );

    bdad_back #(
        .NDIG (NDIG),
        .CW   (CW)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (w_q_empty),
        .i_bcd        (w_q_out[QW-1:CW]),
        .i_top        (w_q_out[CW-1:0]),
        .o_q_pop      (w_q_pop),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule
